/* hw/rtl/hgnt_pkg.sv */
// ----------------------------------------------------------------------------
// hgnt_pkg
// Shared types and constants for the hop gradient neighbor table unit:
// request and response payloads, table entry layout, operation codes and
// the sequencer states.
// ----------------------------------------------------------------------------
package hgnt_pkg;

   localparam int MAX_NEIGHBORS = 16;
   localparam int IDX_W         = $clog2(MAX_NEIGHBORS);

   localparam logic [1:0] OP_PURGE   = 2'd0;
   localparam logic [1:0] OP_MESSAGE = 2'd1;
   localparam logic [1:0] OP_COMPUTE = 2'd2;

   localparam logic [1:0] CSR_IS_ROOT         = 2'd0;
   localparam logic [1:0] CSR_DISTANCE_CUTOFF = 2'd1;
   localparam logic [1:0] CSR_MAX_AGE         = 2'd2;

   localparam logic [15:0] GRAD_UNKNOWN = 16'hFFFF;
   localparam logic [15:0] GRAD_NO_MIN  = 16'hFFFE;

   localparam logic [7:0]  CUTOFF_RESET  = 8'd100;
   localparam logic [15:0] MAX_AGE_RESET = 16'd64;

   // reciprocal of ten for 16-bit operands: q = (x * RECIP_TEN) >> RECIP_SHIFT
   localparam logic [16:0] RECIP_TEN   = 17'd52429;
   localparam int          RECIP_SHIFT = 19;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] current_tick;
      logic [15:0] neighbor_id;
      logic [7:0]  distance_mm;
      logic [7:0]  sender_neighbor_count;
      logic [15:0] sender_gradient;
   } req_type;

   typedef struct packed {
      logic [15:0] hop_value;
      logic [3:0]  neighbor_count;
      logic        value_changed;
      logic        broadcast_enable;
      logic [3:0]  color_index;
   } rsp_type;

   typedef struct packed {
      logic [15:0] id;
      logic [31:0] time_stamp;
      logic [7:0]  distance;
      logic [7:0]  neighbors;
      logic [15:0] gradient;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PRG_RD,
      ST_PRG_EV,
      ST_DIV,
      ST_RESP
   } state_type;

endpackage

/* hw/rtl/hop_gradient_neighbor_table_unit.sv */
// ----------------------------------------------------------------------------
// hop_gradient_neighbor_table_unit
// Neighbor table with hop-count gradient: message update, age purge and
// gradient compute over a table held in a synchronous RAM.
// ----------------------------------------------------------------------------
// One request is worked at a time and gives one response. The neighbor
// table lives in a single RAM with one write and two registered read ports,
// so every table pass is set by that RAM: a message or compute request walks
// the live entries one per cycle (a message stops at a matching id), a purge
// reads and then evaluates each live entry in turn, and a far message or an
// unused code goes straight to the divide and response states. A new
// request is taken as soon as the previous response sits in the output
// register, even while that response is stalled.
module hop_gradient_neighbor_table_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  hgnt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hgnt_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_wdata
);
   import hgnt_pkg::*;

   entry_type mem [MAX_NEIGHBORS];

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] scan_ff, scan_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic             chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic [15:0]      min_ff, min_in;
   logic [15:0]      grad_ff, grad_in;
   logic             changed_ff, changed_in;
   logic [12:0]      quot_ff, quot_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             is_root_ff;
   logic [7:0]       cutoff_ff;
   logic [15:0]      max_age_ff;

   logic [IDX_W-1:0] rd_a_addr, rd_b_addr, wr_addr;
   logic             wr_en;
   entry_type        wr_data;
   entry_type        rd_a_ff, rd_b_ff;

   logic             hit;
   logic [15:0]      min_cur;
   logic [15:0]      next_grad;
   logic [31:0]      age;
   logic [32:0]      prod;
   logic [16:0]      quot_x10;
   logic [16:0]      rem;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         is_root_ff <= 1'b0;
         cutoff_ff  <= CUTOFF_RESET;
         max_age_ff <= MAX_AGE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IS_ROOT:         is_root_ff <= csr_wdata[0];
            CSR_DISTANCE_CUTOFF: cutoff_ff  <= csr_wdata[7:0];
            CSR_MAX_AGE:         max_age_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         grad_ff      <= GRAD_UNKNOWN;
         changed_ff   <= 1'b0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         grad_ff      <= grad_in;
         changed_ff   <= changed_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff     <= req_in;
      scan_ff    <= scan_in;
      k_ff       <= k_in;
      chk_idx_ff <= chk_idx_in;
      min_ff     <= min_in;
      quot_ff    <= quot_in;
      rsp_ff     <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      cnt_in       = cnt_ff;
      scan_in      = scan_ff;
      k_in         = k_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = chk_idx_ff;
      min_in       = min_ff;
      grad_in      = grad_ff;
      changed_in   = changed_ff;
      quot_in      = quot_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      req_stall    = 1'b1;
      rd_a_addr    = scan_ff;
      rd_b_addr    = cnt_ff - 1'b1;
      wr_en        = 1'b0;
      wr_addr      = cnt_ff;
      wr_data      = '{id:         req_ff.neighbor_id,
                       time_stamp: req_ff.current_tick,
                       distance:   req_ff.distance_mm,
                       neighbors:  req_ff.sender_neighbor_count,
                       gradient:   req_ff.sender_gradient};

      hit       = chk_vld_ff && (rd_a_ff.id == req_ff.neighbor_id);
      min_cur   = (chk_vld_ff && (rd_a_ff.gradient < min_ff)) ? rd_a_ff.gradient : min_ff;
      next_grad = (is_root_ff ? 16'd0 : min_cur) + 16'd1;
      age       = req_ff.current_tick - rd_a_ff.time_stamp;
      prod      = grad_ff * RECIP_TEN;
      quot_x10  = {1'b0, quot_ff, 3'b000} + {3'b000, quot_ff, 1'b0};
      rem       = {1'b0, grad_ff} - quot_x10;

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               req_in     = req_data;
               changed_in = 1'b0;
               scan_in    = '0;
               k_in       = cnt_ff;
               min_in     = GRAD_NO_MIN;
               if (req_data.operation == OP_PURGE) begin
                  state_in = ST_PRG_RD;
               end else if (req_data.operation == OP_COMPUTE) begin
                  state_in = ST_SCAN;
               end else if (req_data.operation == OP_MESSAGE &&
                            req_data.distance_mm <= cutoff_ff) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end

         // one entry read per cycle, checked the cycle after
         ST_SCAN: begin
            min_in = min_cur;
            if (req_ff.operation == OP_MESSAGE && hit) begin
               wr_en    = 1'b1;
               wr_addr  = chk_idx_ff;
               state_in = ST_DIV;
            end else if (scan_ff < cnt_ff) begin
               chk_vld_in = 1'b1;
               chk_idx_in = scan_ff;
               scan_in    = scan_ff + 1'b1;
            end else if (req_ff.operation == OP_MESSAGE) begin
               // new sender: append, or land in the spare slot when full
               wr_en = 1'b1;
               if (cnt_ff < IDX_W'(MAX_NEIGHBORS - 1)) begin
                  cnt_in = cnt_ff + 1'b1;
               end
               state_in = ST_DIV;
            end else begin
               grad_in    = next_grad;
               changed_in = (grad_ff != next_grad);
               state_in   = ST_DIV;
            end
         end

         ST_PRG_RD: begin
            rd_a_addr = k_ff - 1'b1;
            if (k_ff == '0) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_PRG_EV;
            end
         end

         // stale entry takes the current last live entry
         ST_PRG_EV: begin
            if (age > {16'd0, max_age_ff}) begin
               wr_en   = 1'b1;
               wr_addr = k_ff - 1'b1;
               wr_data = rd_b_ff;
               cnt_in  = cnt_ff - 1'b1;
            end
            k_in     = k_ff - 1'b1;
            state_in = ST_PRG_RD;
         end

         ST_DIV: begin
            quot_in  = prod[RECIP_SHIFT +: 13];
            state_in = ST_RESP;
         end

         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in = '{hop_value:        grad_ff,
                          neighbor_count:   4'(cnt_ff),
                          value_changed:    changed_ff,
                          broadcast_enable: (grad_ff != GRAD_UNKNOWN),
                          color_index:      rem[3:0]};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the hop gradient neighbor table unit. A shadow
// copy of the neighbor table and gradient predicts one response per
// request. Directed requests hit the table edges, then random phases run
// under several register settings, throttling sender and receiver in the early phases only.
// ----------------------------------------------------------------------------
module tb_top;
   import hgnt_pkg::*;

   localparam logic [1:0] OP_UNUSED  = 2'd3;
   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam int QUIET_LIMIT = 3000;
   localparam int HOLD_AT     = 300;
   localparam int HOLD_LEN    = 400;
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 75;
   localparam int DRAIN_WAIT  = 60;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   hop_gradient_neighbor_table_unit dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .csr_we, .csr_index, .csr_wdata
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow table and register copies
   entry_type   nbr_tbl [MAX_NEIGHBORS];
   int unsigned nbr_live = 0;
   logic [15:0] own_grad = GRAD_UNKNOWN;
   logic        cfg_root = 1'b0;
   logic [7:0]  cfg_cutoff = CUTOFF_RESET;
   logic [15:0] cfg_max_age = MAX_AGE_RESET;

   req_type req_pending_q [$];
   rsp_type expected_rsp_q [$];
   int      n_pushed = 0;
   int      rsp_seen = 0;
   int      mismatch_count = 0;
   int      send_idle_pct = 35;
   int      recv_idle_pct = 53;
   int      hold_left = 0;
   logic    hold_done = 1'b0;
   int      quiet_cycles = 0;
   rsp_type want;

   function automatic rsp_type neighbor_table_step(input req_type r);
      rsp_type     o;
      int unsigned k, i, hit;
      logic [31:0] age;
      int unsigned m;
      logic [15:0] nxt;
      logic        changed;
      changed = 1'b0;
      case (r.operation)
         OP_PURGE: begin
            // walk down, stale slot takes the current last live entry
            for (k = nbr_live; k > 0; k--) begin
               i = k - 1;
               age = r.current_tick - nbr_tbl[i].time_stamp;
               if (age > {16'd0, cfg_max_age}) begin
                  nbr_tbl[i] = nbr_tbl[nbr_live - 1];
                  nbr_live--;
               end
            end
         end
         OP_MESSAGE: begin
            if (r.distance_mm <= cfg_cutoff) begin
               hit = nbr_live;
               for (k = nbr_live; k > 0; k--)
                  if (nbr_tbl[k - 1].id == r.neighbor_id) hit = k - 1;
               // full table: new id lands in the last slot, count stays
               if (hit == nbr_live && nbr_live < MAX_NEIGHBORS - 1) nbr_live++;
               if (hit < MAX_NEIGHBORS) begin
                  nbr_tbl[hit] = '{id: r.neighbor_id, time_stamp: r.current_tick,
                                   distance: r.distance_mm,
                                   neighbors: r.sender_neighbor_count,
                                   gradient: r.sender_gradient};
               end
            end
         end
         OP_COMPUTE: begin
            m = GRAD_NO_MIN;
            for (i = 0; i < nbr_live; i++)
               if (nbr_tbl[i].gradient < m) m = nbr_tbl[i].gradient;
            if (cfg_root) m = 0;
            nxt = 16'(m + 1);
            changed = (own_grad != nxt);
            own_grad = nxt;
         end
         default: ;
      endcase
      o.hop_value        = own_grad;
      o.neighbor_count   = 4'(nbr_live);
      o.value_changed    = changed;
      o.broadcast_enable = (own_grad != GRAD_UNKNOWN);
      o.color_index      = 4'(own_grad % 16'd10);
      return o;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] exp_v);
      if (mismatch_count < 40)
         $display("mismatch %s at response %0d: got %0h, wanted %0h",
                  what, rsp_seen, got, exp_v);
      mismatch_count++;
   endtask

   task automatic offer(input logic [1:0] op, input logic [31:0] tick,
                        input logic [15:0] id, input logic [7:0] range_mm,
                        input logic [7:0] nc, input logic [15:0] grad);
      req_pending_q.push_back('{operation: op, current_tick: tick, neighbor_id: id,
                                distance_mm: range_mm, sender_neighbor_count: nc,
                                sender_gradient: grad});
      n_pushed++;
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_IS_ROOT:         cfg_root = data[0];
         CSR_DISTANCE_CUTOFF: cfg_cutoff = data[7:0];
         CSR_MAX_AGE:         cfg_max_age = data;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_rsp_q.push_back(neighbor_table_step(req_data));
         if (!req_valid || !req_stall) begin
            if (req_pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_data  <= req_pending_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and receiver throttle
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_seen <= rsp_seen + 1;
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("unexpected response", 32'(rsp_data), 32'd0);
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_data.hop_value !== want.hop_value)
                  report_mismatch("hop_value", 32'(rsp_data.hop_value),
                                  32'(want.hop_value));
               if (rsp_data.neighbor_count !== want.neighbor_count)
                  report_mismatch("neighbor_count", 32'(rsp_data.neighbor_count),
                                  32'(want.neighbor_count));
               if (rsp_data.value_changed !== want.value_changed)
                  report_mismatch("value_changed", 32'(rsp_data.value_changed),
                                  32'(want.value_changed));
               if (rsp_data.broadcast_enable !== want.broadcast_enable)
                  report_mismatch("broadcast_enable", 32'(rsp_data.broadcast_enable),
                                  32'(want.broadcast_enable));
               if (rsp_data.color_index !== want.color_index)
                  report_mismatch("color_index", 32'(rsp_data.color_index),
                                  32'(want.color_index));
            end
         end
         // one long hold-off so the unit backs up into its input
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
         end else if (!hold_done && rsp_seen == HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      int          c, n, s, g, step;
      logic [31:0] tick_now;
      logic [15:0] id_base;
      logic [1:0]  op;
      logic [31:0] tick;
      logic [15:0] id;
      logic [7:0]  range_mm;
      logic [15:0] grad;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed requests under reset register values
      offer(OP_COMPUTE, 32'd0, 16'd0, 8'd0, 8'd0, 16'd0);
      offer(OP_PURGE, 32'd0, 16'd0, 8'd0, 8'd0, 16'd0);
      offer(OP_UNUSED, '1, '1, '1, '1, '1);
      offer(OP_MESSAGE, 32'd0, 16'd0, 8'd100, 8'd0, 16'd0);
      offer(OP_MESSAGE, 32'd1, 16'd7, 8'd101, 8'd9, 16'd1);
      offer(OP_MESSAGE, 32'hFFFF_FFFF, 16'hFFFF, 8'd0, 8'hFF, 16'hFFFF);
      offer(OP_MESSAGE, 32'd2, 16'd0, 8'd50, 8'd3, 16'd5);
      offer(OP_COMPUTE, 32'd3, 16'd0, 8'd0, 8'd0, 16'd0);
      offer(OP_COMPUTE, 32'd4, 16'd0, 8'd0, 8'd0, 16'd0);
      // fill past capacity, the last id overflows into the spare slot
      for (n = 1; n <= 14; n++)
         offer(OP_MESSAGE, 32'd20, 16'(n), 8'd10, 8'(n), 16'(100 + n));
      // wrapped timestamp ages out along with the early entries
      offer(OP_PURGE, 32'd75, 16'd0, 8'd0, 8'd0, 16'd0);
      offer(OP_COMPUTE, 32'd76, 16'd0, 8'd0, 8'd0, 16'd0);

      tick_now = 32'd100;
      for (c = 0; c < PHASES; c++) begin
         while (rsp_seen < n_pushed) @(posedge clock);
         if (c >= 2) begin
            send_idle_pct <= (c < 4) ? 53 : 0;
            recv_idle_pct <= (c < 4) ? 35 : 0;
         end
         case (c)
            0: begin
               write_csr(CSR_IS_ROOT, 16'h0001);
               write_csr(CSR_DISTANCE_CUTOFF, 16'h00FF);
               write_csr(CSR_MAX_AGE, 16'hFFFF);
            end
            1: begin
               write_csr(CSR_IS_ROOT, 16'h0000);
               write_csr(CSR_DISTANCE_CUTOFF, 16'h0000);
               write_csr(CSR_MAX_AGE, 16'h0000);
            end
            default: begin
               write_csr(CSR_IS_ROOT, 16'($urandom));
               write_csr(CSR_DISTANCE_CUTOFF, 16'($urandom));
               write_csr(CSR_MAX_AGE, (c == 5) ? 16'($urandom)
                                               : 16'($urandom_range(0, 300)));
               if (c == 2) write_csr(CSR_UNUSED, 16'($urandom));
            end
         endcase
         id_base = 16'($urandom);
         step = cfg_max_age / 4 + 3;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            s = $urandom_range(0, 99);
            op = (s < 55) ? OP_MESSAGE : (s < 75) ? OP_COMPUTE :
                 (s < 95) ? OP_PURGE : OP_UNUSED;
            tick_now = tick_now + $urandom_range(0, step);
            tick = ($urandom_range(0, 99) < 5) ? $urandom : tick_now;
            id = ($urandom_range(0, 99) < 85) ? 16'(id_base + $urandom_range(0, 19))
                                               : 16'($urandom);
            range_mm = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, cfg_cutoff))
                                                     : 8'($urandom);
            g = $urandom_range(0, 99);
            grad = (g < 75) ? 16'($urandom_range(0, 25)) : (g < 85) ? GRAD_NO_MIN :
                   (g < 90) ? GRAD_UNKNOWN : 16'($urandom);
            offer(op, tick, id, range_mm, 8'($urandom), grad);
         end
      end

      while (rsp_seen < n_pushed) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (expected_rsp_q.size() != 0)
         report_mismatch("leftover expectations", expected_rsp_q.size(), 32'd0);
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
